// ===== rtl/tlf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the lateral tyre force block.
// Used by tlf_cordic, tlf_div and tire_lateral_force_magic_formula_top; depends on nothing.
`default_nettype none

package tlf_pkg;

    // Signed Q16.16 value.
    typedef logic signed [31:0] q_t;

    // One input word and one result word.
    typedef struct packed {
        logic [19:0]        fz_load;
        logic signed [19:0] slip_angle;
    } tlf_in_t;

    typedef struct packed {
        logic signed [31:0] lateral_force;
        logic               invalid;
    } tlf_out_t;

    // Coefficient register indexes.
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PEAK_SQ   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PEAK_LIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STIFF_PK  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STIFF_SH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STIFF_LD  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CURVE_SQ  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CURVE_LIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CURVE_OFS = 3'd7;

    // Q16.16 constants.
    localparam q_t   C_SHAPE_Q    = 32'sd85197;
    localparam q_t   RAD_TO_DEG_Q = 32'sd3754937;
    localparam q_t   ONE_Q        = 32'sd65536;
    localparam int   PI_Q         = 205887;
    localparam int   HALF_PI_Q    = 102944;
    localparam int   TWO_PI_Q     = 411775;
    localparam int   INV_GAIN_Q   = 39797;

    // floor(2^48 / TWO_PI_Q); the estimate it gives is never high and never more than one low.
    localparam logic [29:0] TWO_PI_RECIP = 30'd683564997;
    localparam int unsigned RECIP_SHIFT  = 48;

    // CORDIC arctangent table, Q16.16.
    localparam int unsigned ATAN_STEPS = 16;
    localparam logic [15:0] ATAN_TAB [ATAN_STEPS] = '{
        16'd51472, 16'd30385, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
    };

    // Clamp a wide signed value to the 32-bit range.
    function automatic q_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product, rounded half up, saturated.
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        logic signed [64:0] r;
        p = a * b;
        r = 65'(p) + 65'sd32768;
        return sat32(66'(r >>> 16));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tlf_cordic.sv =====
// Pipelined 16-step CORDIC: arctangent (vectoring) or sine with angle reduction (rotation).
// Carries a side word alongside each item; uses tlf_pkg.
`default_nettype none

module tlf_cordic #(
    parameter bit          SINE   = 1'b0,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire tlf_pkg::q_t        arg,
    input  wire logic [SIDE_W-1:0]  in_side,
    output logic                    out_valid,
    output tlf_pkg::q_t             res,
    output logic [SIDE_W-1:0]       out_side
);
    import tlf_pkg::*;

    localparam int unsigned XW = 34;
    localparam int unsigned ZW = 21;
    localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_Q);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q);
    localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(TWO_PI_Q);

    logic                    v_reg    [ATAN_STEPS+1];
    logic signed [XW-1:0]    x_reg    [ATAN_STEPS+1];
    logic signed [XW-1:0]    y_reg    [ATAN_STEPS+1];
    logic signed [ZW-1:0]    z_reg    [ATAN_STEPS+1];
    logic                    zero_reg [ATAN_STEPS+1];
    logic [SIDE_W-1:0]       side_reg [ATAN_STEPS+1];

    if (SINE)
    begin : g_sine_front
        logic              f1_v_reg, f2_v_reg, f3_v_reg;
        logic [12:0]       f1_q_reg;
        logic [31:0]       f1_mag_reg;
        logic              f1_neg_reg, f2_neg_reg;
        logic [19:0]       f2_rem_reg;
        logic signed [ZW-1:0] f3_r_reg;
        logic [SIDE_W-1:0] f1_side_reg, f2_side_reg, f3_side_reg;
        logic [31:0]       mag;
        logic [60:0]       prod;
        logic [31:0]       qd;
        logic [18:0]       rc;
        logic signed [ZW-1:0] rm, rs, r1, r2, rf;

        // Quotient estimate of |arg| / 2pi by reciprocal multiplication.
        assign mag  = arg[31] ? 32'(-arg) : 32'(arg);
        assign prod = 61'(mag) * 61'(TWO_PI_RECIP);
        // Remainder from the estimate, then one correction and the sign.
        assign qd = 32'(f1_q_reg) * 32'(TWO_PI_Q);
        assign rc = (f2_rem_reg >= 20'(TWO_PI_Q)) ? 19'(f2_rem_reg - 20'(TWO_PI_Q))
                                                  : 19'(f2_rem_reg);
        assign rm = $signed(ZW'(rc));
        assign rs = f2_neg_reg ? -rm : rm;
        // Wrap into one turn around zero, then fold onto the right half plane.
        assign r1 = (f3_r_reg > PI_Z) ? f3_r_reg - TWO_PI_Z : f3_r_reg;
        assign r2 = (r1 <= -PI_Z) ? r1 + TWO_PI_Z : r1;
        assign rf = (r2 > HALF_PI_Z) ? PI_Z - r2 : ((r2 < -HALF_PI_Z) ? -PI_Z - r2 : r2);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                f1_v_reg <= 1'b0;
                f2_v_reg <= 1'b0;
                f3_v_reg <= 1'b0;
                v_reg[0] <= 1'b0;
            end
            else
            begin
                f1_v_reg <= in_valid;
                f2_v_reg <= f1_v_reg;
                f3_v_reg <= f2_v_reg;
                v_reg[0] <= f3_v_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            f1_q_reg    <= prod[RECIP_SHIFT+12:RECIP_SHIFT];
            f1_mag_reg  <= mag;
            f1_neg_reg  <= arg[31];
            f1_side_reg <= in_side;
            f2_rem_reg  <= 20'(f1_mag_reg - qd);
            f2_neg_reg  <= f1_neg_reg;
            f2_side_reg <= f1_side_reg;
            f3_r_reg    <= rs;
            f3_side_reg <= f2_side_reg;
            x_reg[0]    <= XW'(INV_GAIN_Q);
            y_reg[0]    <= '0;
            z_reg[0]    <= rf;
            zero_reg[0] <= 1'b0;
            side_reg[0] <= f3_side_reg;
        end
    end
    else
    begin : g_atan_front
        // Vectoring starts from (1.0, arg); a zero argument gives zero.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[0] <= 1'b0;
            end
            else
            begin
                v_reg[0] <= in_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[0]    <= XW'(ONE_Q);
            y_reg[0]    <= XW'(arg);
            z_reg[0]    <= '0;
            zero_reg[0] <= (arg == '0);
            side_reg[0] <= in_side;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < ATAN_STEPS; i++)
    begin : g_step
        logic cw;

        assign cw = SINE ? (z_reg[i] < 0) : (y_reg[i] > 0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (cw)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + $signed(ZW'(ATAN_TAB[i]));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - $signed(ZW'(ATAN_TAB[i]));
            end
            zero_reg[i+1] <= zero_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    // Result of the last stage.
    assign out_valid = v_reg[ATAN_STEPS];
    assign out_side  = side_reg[ATAN_STEPS];
    assign res = SINE ? 32'(y_reg[ATAN_STEPS])
                      : (zero_reg[ATAN_STEPS] ? '0 : 32'(z_reg[ATAN_STEPS]));

endmodule

`default_nettype wire

// ===== rtl/tlf_div.sv =====
// Pipelined restoring divider for Q16.16 quotients, one quotient bit per stage.
// Carries a side word alongside each item; uses tlf_pkg.
`default_nettype none

module tlf_div #(
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire tlf_pkg::q_t        num,
    input  wire tlf_pkg::q_t        den,
    input  wire logic [SIDE_W-1:0]  in_side,
    output logic                    out_valid,
    output tlf_pkg::q_t             quot,
    output logic [SIDE_W-1:0]       out_side
);
    import tlf_pkg::*;

    localparam int unsigned DW = 32;
    localparam int unsigned NW = DW + 16;

    logic              v_reg    [NW+1];
    logic [DW-1:0]     r_reg    [NW+1];
    logic [NW-1:0]     nq_reg   [NW+1];
    logic [DW-1:0]     d_reg    [NW+1];
    logic              neg_reg  [NW+1];
    logic              dz_reg   [NW+1];
    logic [SIDE_W-1:0] side_reg [NW+1];
    logic              ov_reg;
    q_t                quot_reg;
    logic [SIDE_W-1:0] oside_reg;
    logic [DW-1:0]     nmag, dmag;
    logic [NW-1:0]     qm, qn;

    // Magnitudes of the scaled dividend and of the divisor.
    assign nmag = num[31] ? 32'(-num) : 32'(num);
    assign dmag = den[31] ? 32'(-den) : 32'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]    <= '0;
        nq_reg[0]   <= {nmag, 16'b0};
        d_reg[0]    <= dmag;
        neg_reg[0]  <= num[31] ^ den[31];
        dz_reg[0]   <= (den == '0);
        side_reg[0] <= in_side;
    end

    // One trial subtraction per stage; quotient bits shift in as dividend bits shift out.
    for (genvar i = 0; i < NW; i++)
    begin : g_step
        logic [DW:0] rs;
        logic        ge;

        assign rs = {r_reg[i], nq_reg[i][NW-1]};
        assign ge = (rs >= {1'b0, d_reg[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[i+1]    <= ge ? DW'(rs - {1'b0, d_reg[i]}) : DW'(rs);
            nq_reg[i+1]   <= {nq_reg[i][NW-2:0], ge};
            d_reg[i+1]    <= d_reg[i];
            neg_reg[i+1]  <= neg_reg[i];
            dz_reg[i+1]   <= dz_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    // Sign and saturation of the quotient.
    assign qm = nq_reg[NW];
    assign qn = -qm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= v_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dz_reg[NW])
        begin
            quot_reg <= '0;
        end
        else if (neg_reg[NW])
        begin
            quot_reg <= (qm > 48'h0000_8000_0000) ? 32'sh80000000 : qn[31:0];
        end
        else
        begin
            quot_reg <= (qm > 48'h0000_7FFF_FFFF) ? 32'sh7FFFFFFF : qm[31:0];
        end
        oside_reg <= side_reg[NW];
    end

    assign out_valid = ov_reg;
    assign quot      = quot_reg;
    assign out_side  = oside_reg;

endmodule

`default_nettype wire

// ===== rtl/tire_lateral_force_magic_formula_top.sv =====
// Top level of the lateral tyre force pipeline (magic formula without camber).
// Depends on tlf_pkg, tlf_cordic and tlf_div.
//
// The block takes one load/slip word in every clock cycle (busy stays low) and
// returns each result in order, with done high for exactly one cycle; the
// receiver cannot stall it. Each word passes through the chain of three 17-stage
// arctangent units, two 20-stage sine units and two 50-stage dividers (one
// quotient bit per stage), plus the multiply stages between them.
// Coefficients are written through the cfg channel, which is always ready;
// write them only while no word is in flight.
`default_nettype none

module tire_lateral_force_magic_formula_top #(
    parameter int unsigned CFG_INDEX_W = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire tlf_pkg::tlf_in_t       item,
    output logic                        done,
    output tlf_pkg::tlf_out_t           result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);
    import tlf_pkg::*;

    typedef struct packed { q_t cd; q_t d; q_t e; q_t alpha; } side_a_t;
    typedef struct packed { q_t d; q_t e; q_t alpha; logic cd_zero; } side_b_t;
    typedef struct packed { q_t b; q_t d; q_t e; q_t ome; q_t alpha; logic bad; } side_c_t;
    typedef struct packed { q_t t2; q_t p1; q_t b; q_t d; logic bad; } side_d_t;
    typedef struct packed { q_t d; logic bad; } side_e_t;

    // Coefficient registers.
    q_t   a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg, a7_reg, a8_reg;
    logic cfg_hit;

    assign cfg_hit = ((cfg_index >> REG_IDX_W) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= '0;
            a2_reg <= '0;
            a3_reg <= '0;
            a4_reg <= '0;
            a5_reg <= '0;
            a6_reg <= '0;
            a7_reg <= '0;
            a8_reg <= '0;
        end
        else if (cfg_valid && cfg_hit)
        begin
            unique case (cfg_index[REG_IDX_W-1:0])
                REG_PEAK_SQ:   a1_reg <= cfg_data;
                REG_PEAK_LIN:  a2_reg <= cfg_data;
                REG_STIFF_PK:  a3_reg <= cfg_data;
                REG_STIFF_SH:  a4_reg <= cfg_data;
                REG_STIFF_LD:  a5_reg <= cfg_data;
                REG_CURVE_SQ:  a6_reg <= cfg_data;
                REG_CURVE_LIN: a7_reg <= cfg_data;
                REG_CURVE_OFS: a8_reg <= cfg_data;
            endcase
        end
    end

    // Pipeline registers between the units.
    logic              s0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic              s6_v_reg, s7_v_reg, s8_v_reg, s9_v_reg, s10_v_reg, s11_v_reg;
    logic              s12_v_reg, done_reg;
    logic [25:0]       s0_fz_reg;
    logic signed [19:0] s0_slip_reg;
    q_t                s1_fz2_reg, s1_a5fz_reg, s1_a2fz_reg, s1_a7fz_reg, s1_alpha_reg;
    q_t                s2_a1fz2_reg, s2_a6fz2_reg, s2_a2fz_reg, s2_a7fz_reg;
    q_t                s2_a5fz_reg, s2_alpha_reg;
    q_t                s3_d_reg, s3_e_reg, s3_a5fz_reg, s3_alpha_reg;
    q_t                s4_a5fz_reg;
    side_a_t           s4_side_reg;
    q_t                s5_m_reg;
    side_a_t           s5_side_reg;
    q_t                s6_bcd_reg, s6_cd_reg;
    side_b_t           s6_side_reg;
    q_t                s7_ba_reg;
    side_c_t           s7_side_reg;
    q_t                s8_e_reg;
    side_d_t           s8_side_reg;
    q_t                s9_p2_reg;
    side_d_t           s9_side_reg;
    q_t                s10_phi_reg, s10_b_reg;
    side_e_t           s10_side_reg;
    q_t                s11_bp_reg;
    side_e_t           s11_side_reg;
    q_t                s12_cm_reg;
    side_e_t           s12_side_reg;
    tlf_out_t          result_reg;

    // Unit outputs.
    logic    at1_v, sn1_v, dv1_v, at2_v, dv2_v, at3_v, sn2_v;
    q_t      at1_res, sn1_res, dv1_q, at2_res, dv2_q, at3_res, sn2_res;
    side_a_t at1_side, sn1_side;
    side_b_t dv1_side;
    side_c_t at2_side;
    side_d_t dv2_side;
    side_e_t at3_side, sn2_side;

    q_t fz_q;

    assign fz_q = $signed({6'b0, s0_fz_reg});

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            s12_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            s0_v_reg  <= start;
            s1_v_reg  <= s0_v_reg;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= at1_v;
            s6_v_reg  <= sn1_v;
            s7_v_reg  <= dv1_v;
            s8_v_reg  <= at2_v;
            s9_v_reg  <= dv2_v;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
            s12_v_reg <= at3_v;
            done_reg  <= sn2_v;
        end
    end

    // Load products, peak factor, curvature and slip in degrees.
    always_ff @(posedge clk)
    begin
        s0_fz_reg    <= {item.fz_load, 6'b0};
        s0_slip_reg  <= item.slip_angle;

        s1_fz2_reg   <= qmul(fz_q, fz_q);
        s1_a5fz_reg  <= qmul(a5_reg, fz_q);
        s1_a2fz_reg  <= qmul(a2_reg, fz_q);
        s1_a7fz_reg  <= qmul(a7_reg, fz_q);
        s1_alpha_reg <= qmul(32'(s0_slip_reg), RAD_TO_DEG_Q);

        s2_a1fz2_reg <= qmul(a1_reg, s1_fz2_reg);
        s2_a6fz2_reg <= qmul(a6_reg, s1_fz2_reg);
        s2_a2fz_reg  <= s1_a2fz_reg;
        s2_a7fz_reg  <= s1_a7fz_reg;
        s2_a5fz_reg  <= s1_a5fz_reg;
        s2_alpha_reg <= s1_alpha_reg;

        s3_d_reg     <= sat32(66'(s2_a1fz2_reg) + 66'(s2_a2fz_reg));
        s3_e_reg     <= sat32(66'(s2_a6fz2_reg) + 66'(s2_a7fz_reg) + 66'(a8_reg));
        s3_a5fz_reg  <= s2_a5fz_reg;
        s3_alpha_reg <= s2_alpha_reg;

        s4_a5fz_reg       <= s3_a5fz_reg;
        s4_side_reg.cd    <= qmul(C_SHAPE_Q, s3_d_reg);
        s4_side_reg.d     <= s3_d_reg;
        s4_side_reg.e     <= s3_e_reg;
        s4_side_reg.alpha <= s3_alpha_reg;
    end

    // Stiffness: a3 * sin(a4 * atan(a5 * Fz)).
    tlf_cordic #(
        .SINE   (1'b0),
        .SIDE_W ($bits(side_a_t))
    ) u_atan_load (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_v_reg),
        .arg       (s4_a5fz_reg),
        .in_side   (s4_side_reg),
        .out_valid (at1_v),
        .res       (at1_res),
        .out_side  (at1_side)
    );

    always_ff @(posedge clk)
    begin
        s5_m_reg    <= qmul(a4_reg, at1_res);
        s5_side_reg <= at1_side;
    end

    tlf_cordic #(
        .SINE   (1'b1),
        .SIDE_W ($bits(side_a_t))
    ) u_sin_stiff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_v_reg),
        .arg       (s5_m_reg),
        .in_side   (s5_side_reg),
        .out_valid (sn1_v),
        .res       (sn1_res),
        .out_side  (sn1_side)
    );

    always_ff @(posedge clk)
    begin
        s6_bcd_reg           <= qmul(a3_reg, sn1_res);
        s6_cd_reg            <= sn1_side.cd;
        s6_side_reg.d        <= sn1_side.d;
        s6_side_reg.e        <= sn1_side.e;
        s6_side_reg.alpha    <= sn1_side.alpha;
        s6_side_reg.cd_zero  <= (sn1_side.cd == '0);
    end

    // B = BCD / (C * D).
    tlf_div #(
        .SIDE_W ($bits(side_b_t))
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_v_reg),
        .num       (s6_bcd_reg),
        .den       (s6_cd_reg),
        .in_side   (s6_side_reg),
        .out_valid (dv1_v),
        .quot      (dv1_q),
        .out_side  (dv1_side)
    );

    always_ff @(posedge clk)
    begin
        s7_ba_reg         <= qmul(dv1_q, dv1_side.alpha);
        s7_side_reg.b     <= dv1_q;
        s7_side_reg.d     <= dv1_side.d;
        s7_side_reg.e     <= dv1_side.e;
        s7_side_reg.ome   <= sat32(66'(ONE_Q) - 66'(dv1_side.e));
        s7_side_reg.alpha <= dv1_side.alpha;
        s7_side_reg.bad   <= dv1_side.cd_zero || (dv1_q == '0);
    end

    // atan(B * alpha).
    tlf_cordic #(
        .SINE   (1'b0),
        .SIDE_W ($bits(side_c_t))
    ) u_atan_slip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s7_v_reg),
        .arg       (s7_ba_reg),
        .in_side   (s7_side_reg),
        .out_valid (at2_v),
        .res       (at2_res),
        .out_side  (at2_side)
    );

    always_ff @(posedge clk)
    begin
        s8_e_reg        <= at2_side.e;
        s8_side_reg.t2  <= at2_res;
        s8_side_reg.p1  <= qmul(at2_side.ome, at2_side.alpha);
        s8_side_reg.b   <= at2_side.b;
        s8_side_reg.d   <= at2_side.d;
        s8_side_reg.bad <= at2_side.bad;
    end

    // E / B.
    tlf_div #(
        .SIDE_W ($bits(side_d_t))
    ) u_div_e (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s8_v_reg),
        .num       (s8_e_reg),
        .den       (s8_side_reg.b),
        .in_side   (s8_side_reg),
        .out_valid (dv2_v),
        .quot      (dv2_q),
        .out_side  (dv2_side)
    );

    // phi = (1 - E) * alpha + (E / B) * atan(B * alpha), then B * phi.
    always_ff @(posedge clk)
    begin
        s9_p2_reg        <= qmul(dv2_q, dv2_side.t2);
        s9_side_reg      <= dv2_side;

        s10_phi_reg      <= sat32(66'(s9_side_reg.p1) + 66'(s9_p2_reg));
        s10_b_reg        <= s9_side_reg.b;
        s10_side_reg.d   <= s9_side_reg.d;
        s10_side_reg.bad <= s9_side_reg.bad;

        s11_bp_reg       <= qmul(s10_b_reg, s10_phi_reg);
        s11_side_reg     <= s10_side_reg;
    end

    tlf_cordic #(
        .SINE   (1'b0),
        .SIDE_W ($bits(side_e_t))
    ) u_atan_phi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s11_v_reg),
        .arg       (s11_bp_reg),
        .in_side   (s11_side_reg),
        .out_valid (at3_v),
        .res       (at3_res),
        .out_side  (at3_side)
    );

    always_ff @(posedge clk)
    begin
        s12_cm_reg   <= qmul(C_SHAPE_Q, at3_res);
        s12_side_reg <= at3_side;
    end

    tlf_cordic #(
        .SINE   (1'b1),
        .SIDE_W ($bits(side_e_t))
    ) u_sin_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s12_v_reg),
        .arg       (s12_cm_reg),
        .in_side   (s12_side_reg),
        .out_valid (sn2_v),
        .res       (sn2_res),
        .out_side  (sn2_side)
    );

    // Output word: Fy = D * sin(...), forced to zero when a divisor was zero.
    always_ff @(posedge clk)
    begin
        result_reg.lateral_force <= sn2_side.bad ? '0 : qmul(sn2_side.d, sn2_res);
        result_reg.invalid       <= sn2_side.bad;
    end

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // An invalid word always carries a zero force.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.invalid |-> result_reg.lateral_force == '0)
        else $error("invalid result with non-zero force");

    // A zero C*D must give a zero B from the divider.
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dv1_v && dv1_side.cd_zero |-> dv1_q == '0)
        else $error("divider gave non-zero quotient for zero divisor");

    // A zero B must mark the word invalid.
    a_zero_b_bad: assert property (@(posedge clk) disable iff (!rst_n)
        s7_v_reg && (s7_side_reg.b == '0) |-> s7_side_reg.bad)
        else $error("zero stiffness factor not flagged");

endmodule

`default_nettype wire
